// ----- rtl/core/abnf_pkg.sv -----
// ----------------------------------------------------------------------------
// abnf_pkg: shared types and constants
// Offset width, event codes, start code lengths and the job record that
// travels from the byte scanner to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package abnf_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int OUT_BITS    = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] START_BYTE    = 8'h01;
   localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;

   localparam logic [2:0] CLEN_SHORT = 3'd3;
   localparam logic [2:0] CLEN_LONG  = 3'd4;

   localparam logic [1:0] ZRUN_MAX = 2'd3;

   typedef enum logic [1:0] {
      EV_HEADER = 2'd0,
      EV_END    = 2'd1,
      EV_TRUNC  = 2'd2
   } event_kind_type;

   typedef enum logic {
      PH_FIRST  = 1'b0,
      PH_SECOND = 1'b1
   } back_phase_type;

   // one accepted byte that produced results; two = header then truncation
   typedef struct packed {
      event_kind_type         kind;
      logic                   two;
      logic [4:0]             hdr_code;
      logic [2:0]             clen;
      logic [OFFSET_BITS-1:0] off;
      logic [OFFSET_BITS-1:0] endo;
   } job_type;

   function automatic logic [OUT_BITS-1:0] out_word(input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+OUT_BITS-1:0] w;
      w = {{OUT_BITS{1'b0}}, v};
      return w[OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/abnf_if.sv -----
// ----------------------------------------------------------------------------
// abnf_if: byte and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface abnf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface abnf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [4:0]  hdr_code;
   logic [2:0]  start_code_len;
   logic [31:0] nal_offset;
   logic [31:0] end_offset;
   logic [31:0] nal_length;
   logic        last_of_run;

   modport source (output valid, output event_kind, output hdr_code, output start_code_len,
                   output nal_offset, output end_offset, output nal_length,
                   output last_of_run, input ready);
   modport sink   (input valid, input event_kind, input hdr_code, input start_code_len,
                   input nal_offset, input end_offset, input nal_length,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/abnf_front.sv -----
// ----------------------------------------------------------------------------
// abnf_front: byte scanner
// Tracks zero runs and NAL state per byte; pushes a job for each byte
// that produces at least one result.
// ----------------------------------------------------------------------------
`default_nettype none

module abnf_front (
   input  wire logic            clock,
   input  wire logic            reset,
   abnf_req_if.sink             req_ch,
   input  wire logic            q_full,
   output logic                 q_push,
   output abnf_pkg::job_type    q_job
);
   import abnf_pkg::*;

   logic [1:0]             zr_ff, zr_in;
   logic                   in_nal_ff, in_nal_in;
   logic                   hp_ff, hp_in;
   logic [2:0]             clen_ff, clen_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] open_off_ff, open_off_in;
   logic [4:0]             open_type_ff, open_type_in;

   logic       acc;
   logic [7:0] b;
   logic       fin;
   logic       run2;
   logic       end_hit;
   logic       start_hit;
   logic       in_nal_next;
   logic       trunc;
   logic [7:0] type_byte;

   assign req_ch.ready = !q_full;
   assign acc          = req_ch.valid && !q_full;
   assign b            = req_ch.data_byte;
   assign fin          = req_ch.stream_end;
   assign run2         = zr_ff >= 2'd2;
   assign type_byte    = b & NAL_TYPE_MASK;

   assign end_hit     = !hp_ff && in_nal_ff && run2 && (b <= START_BYTE);
   assign start_hit   = !hp_ff && run2 && (b == START_BYTE);
   assign in_nal_next = hp_ff ? 1'b1 : (end_hit ? 1'b0 : in_nal_ff);
   assign trunc       = fin && in_nal_next;

   always_comb begin
      q_push        = acc && (hp_ff || end_hit || trunc);
      q_job.two     = hp_ff && fin;
      q_job.clen    = clen_ff;
      if (hp_ff) begin
         q_job.kind     = EV_HEADER;
         q_job.hdr_code = type_byte[4:0];
         q_job.off      = pos_ff;
      end else begin
         q_job.kind     = end_hit ? EV_END : EV_TRUNC;
         q_job.hdr_code = open_type_ff;
         q_job.off      = open_off_ff;
      end
      // end sits two bytes back, at the first zero of the terminating run
      q_job.endo = end_hit ? (pos_ff - OFFSET_BITS'(2)) : (pos_ff + OFFSET_BITS'(1));
   end

   always_comb begin
      zr_in        = zr_ff;
      in_nal_in    = in_nal_ff;
      hp_in        = hp_ff;
      clen_in      = clen_ff;
      pos_in       = pos_ff;
      open_off_in  = open_off_ff;
      open_type_in = open_type_ff;
      if (acc) begin
         in_nal_in = in_nal_next;
         pos_in    = pos_ff + OFFSET_BITS'(1);
         if (hp_ff) begin
            hp_in        = 1'b0;
            open_off_in  = pos_ff;
            open_type_in = type_byte[4:0];
         end else if (start_hit) begin
            hp_in   = 1'b1;
            clen_in = (zr_ff == ZRUN_MAX) ? CLEN_LONG : CLEN_SHORT;
         end
         if (b == 8'h00) begin
            zr_in = (zr_ff == ZRUN_MAX) ? ZRUN_MAX : zr_ff + 2'd1;
         end else begin
            zr_in = 2'd0;
         end
         if (fin) begin
            zr_in        = 2'd0;
            in_nal_in    = 1'b0;
            hp_in        = 1'b0;
            clen_in      = CLEN_SHORT;
            pos_in       = '0;
            open_off_in  = '0;
            open_type_in = 5'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zr_ff        <= 2'd0;
         in_nal_ff    <= 1'b0;
         hp_ff        <= 1'b0;
         clen_ff      <= CLEN_SHORT;
         pos_ff       <= '0;
         open_off_ff  <= '0;
         open_type_ff <= 5'd0;
      end else begin
         zr_ff        <= zr_in;
         in_nal_ff    <= in_nal_in;
         hp_ff        <= hp_in;
         clen_ff      <= clen_in;
         pos_ff       <= pos_in;
         open_off_ff  <= open_off_in;
         open_type_ff <= open_type_in;
      end
   end

   // a pending header never coexists with an open NAL
   a_hp_excl: assert property (@(posedge clock) disable iff (reset)
      !(hp_ff && in_nal_ff))
      else $error("header pending while NAL open");

   // final byte returns the scanner to its reset state
   a_fin_clear: assert property (@(posedge clock) disable iff (reset)
      acc && fin |=> (pos_ff == '0) && !in_nal_ff && !hp_ff && (zr_ff == 2'd0))
      else $error("state not cleared after stream end");

endmodule

`default_nettype wire

// ----- rtl/core/abnf_queue.sv -----
// ----------------------------------------------------------------------------
// abnf_queue: job queue
// Small register FIFO between the byte scanner and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module abnf_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  abnf_pkg::job_type    push_job,
   output logic                 full,
   input  wire logic            pop,
   output logic                 head_valid,
   output abnf_pkg::job_type    head_job
);
   import abnf_pkg::*;

   job_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in;
   logic [QPTR_BITS-1:0] rd_ff, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = cnt_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_BITS'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + QPTR_BITS'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count out of range");

   // fill level follows the pointers
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) == cnt_ff[QPTR_BITS-1:0])
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/core/abnf_back.sv -----
// ----------------------------------------------------------------------------
// abnf_back: result stage
// Expands each job into one or two results and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module abnf_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            head_valid,
   input  abnf_pkg::job_type    head_job,
   output logic                 pop,
   abnf_rsp_if.source           rsp_ch
);
   import abnf_pkg::*;

   back_phase_type phase_ff, phase_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           kind_ff, kind_in;
   logic [4:0]           type_ff, type_in;
   logic [2:0]           clen_ff, clen_in;
   logic [OUT_BITS-1:0]  off_ff, off_in;
   logic [OUT_BITS-1:0]  endo_ff, endo_in;
   logic [OUT_BITS-1:0]  len_ff, len_in;
   logic                 last_ff, last_in;

   logic                   load;
   logic                   second;
   logic                   hdr;
   logic [OFFSET_BITS-1:0] diff;

   assign load = head_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign diff = head_job.endo - head_job.off;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_FIRST: begin
            if (load && head_job.two) begin
               phase_in = PH_SECOND;
            end
         end
         PH_SECOND: begin
            if (load) begin
               phase_in = PH_FIRST;
            end
         end
         default: phase_in = PH_FIRST;
      endcase
   end

   always_comb begin
      second  = phase_ff == PH_SECOND;
      hdr     = !second && (head_job.kind == EV_HEADER);
      pop     = load && (second || !head_job.two);
      kind_in = second ? EV_TRUNC : head_job.kind;
      type_in = head_job.hdr_code;
      clen_in = head_job.clen;
      off_in  = out_word(head_job.off);
      endo_in = hdr ? '0 : out_word(head_job.endo);
      len_in  = hdr ? '0 : out_word(diff);
      last_in = second || !head_job.two;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         type_ff <= type_in;
         clen_ff <= clen_in;
         off_ff  <= off_in;
         endo_ff <= endo_in;
         len_ff  <= len_in;
         last_ff <= last_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.event_kind     = kind_ff;
   assign rsp_ch.hdr_code       = type_ff;
   assign rsp_ch.start_code_len = clen_ff;
   assign rsp_ch.nal_offset     = off_ff;
   assign rsp_ch.end_offset     = endo_ff;
   assign rsp_ch.nal_length     = len_ff;
   assign rsp_ch.last_of_run    = last_ff;

   // second half of a pair: first result still held, its job still queued
   a_second_ctx: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SECOND) |-> rsp_valid_ff && head_valid && !last_ff)
      else $error("second result without its first");

   // a job leaves the queue only with its final result
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && last_ff)
      else $error("job popped before its last result");

endmodule

`default_nettype wire

// ----- rtl/core/annexb_nal_boundary_finder_unit.sv -----
// ----------------------------------------------------------------------------
// annexb_nal_boundary_finder_unit: H.264 Annex B start code parser
// Scans a byte stream for 00 00 01 start codes and reports NAL headers,
// NAL ends and NAL truncation at the stream end.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                          moves when
//  req_ch    in   data_byte[8], stream_end[1]                      valid & ready
//  rsp_ch    out  event_kind[2], hdr_code[5], start_code_len[3],   valid & ready
//                 nal_offset[32], end_offset[32], nal_length[32],
//                 last_of_run[1]
//
//  Throughput is one byte per cycle while the job queue is not full. A byte
//  that yields two results (a header on the final byte) occupies the result
//  register for both in turn. The scanner pushes a job at the edge that
//  accepts its byte; the result register loads it from the queue head once
//  it is free or being emptied. Reset is synchronous; there is no clearing
//  pass, the block is ready as soon as reset is released.
//  req_ch.ready drops only when the four-entry job queue is full; with the
//  result side stalled the scanner backs up after five result-producing bytes
//  (one job in the result register, four queued), or four when the first job
//  carries two results.
//  Offsets run modulo 2^OFFSET_BITS and are cut to 32 bits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_boundary_finder_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   abnf_req_if.sink     req_ch,
   abnf_rsp_if.source   rsp_ch
);
   import abnf_pkg::*;

   logic    q_push;
   job_type q_job;
   logic    q_full;
   logic    q_pop;
   logic    q_head_valid;
   job_type q_head_job;

   // front: zero-run tracking and NAL state, one byte per cycle while the job queue is not full
   abnf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job)
   );

   // queue decouples the scanner from result back-pressure
   abnf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // back: length subtract and the output register
   abnf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_annexb_nal_boundary_finder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_annexb_nal_boundary_finder_unit: self-checking bench for the NAL scanner
// Runs a short directed table of Annex B byte sequences, then random streams
// of start codes, headers and payload bytes with noise mixed in. Both sides
// stall at random. Every result is checked field by field against a
// byte-level parser model kept in the bench, or against the result typed into a directed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_annexb_nal_boundary_finder_unit;
   import abnf_pkg::*;

   localparam int RANDOM_BYTES  = 1300;
   localparam int HOLD_AT       = 500;    // bytes sent before the long result stall
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_AT      = 900;    // bytes sent before the sender pauses to drain
   localparam int TAIL_CYCLES   = 8;

   typedef struct {
      event_kind_type kind;
      logic [4:0]     hdr_code;
      logic [2:0]     clen;
      logic [31:0]    off;
      logic [31:0]    endo;
      logic [31:0]    len;
      logic           last;
   } nal_event_type;

   typedef struct {
      logic [7:0]    b;
      bit            fin;
      bit            known;   // expected result typed into the row
      nal_event_type ev;
   } table_row_type;

   logic clock;
   logic reset;

   abnf_req_if req_ch ();
   abnf_rsp_if rsp_ch ();

   annexb_nal_boundary_finder_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Parser model state
   // -------------------------------------------------------------------------
   logic [1:0]             zeros_seen;
   bit                     in_nal;
   bit                     header_due;
   logic [2:0]             code_len;
   logic [OFFSET_BITS-1:0] stream_pos;
   logic [OFFSET_BITS-1:0] open_start;
   logic [4:0]             nal_kind;

   nal_event_type nal_events_due[$];
   table_row_type directed_rows[$];
   nal_event_type no_event;
   nal_event_type want;

   int  failures;
   int  bytes_sent;
   bit  tx_steady;     // sender runs without gaps for the current stream
   bit  rx_holding;    // receiver is in its long stall

   function automatic nal_event_type make_event(input event_kind_type kind,
                                                input logic [4:0] ty,
                                                input logic [2:0] clen,
                                                input logic [31:0] off,
                                                input logic [31:0] endo,
                                                input logic [31:0] len,
                                                input logic last);
      nal_event_type e;
      e.kind     = kind;
      e.hdr_code = ty;
      e.clen     = clen;
      e.off      = off;
      e.endo     = endo;
      e.len      = len;
      e.last     = last;
      return e;
   endfunction

   function automatic void clear_parser();
      zeros_seen = '0;
      in_nal     = 1'b0;
      header_due = 1'b0;
      code_len   = CLEN_SHORT;
      stream_pos = '0;
      open_start = '0;
      nal_kind   = '0;
   endfunction

   // Advance the parser by one byte; queue its events when keep is set.
   function automatic void parse_byte(input logic [7:0] b, input bit fin, input bit keep);
      nal_event_type          evs[$];
      logic [OFFSET_BITS-1:0] p;
      logic [OFFSET_BITS-1:0] endo;
      logic [1:0]             prior;
      p     = stream_pos;
      prior = zeros_seen;
      if (header_due) begin
         // header byte: opens the NAL, still counts toward zero runs below
         header_due = 1'b0;
         in_nal     = 1'b1;
         open_start = p;
         nal_kind   = b[4:0];
         evs.push_back(make_event(EV_HEADER, b[4:0], code_len, p, '0, '0, 1'b0));
      end else begin
         // 00 00 00 or 00 00 01 closes the open NAL two bytes back
         if (in_nal && prior >= 2 && b <= START_BYTE) begin
            endo = p - 2;
            evs.push_back(make_event(EV_END, nal_kind, code_len, open_start, endo,
                                     endo - open_start, 1'b0));
            in_nal = 1'b0;
         end
         if (prior >= 2 && b == START_BYTE) begin
            header_due = 1'b1;
            code_len   = (prior == ZRUN_MAX) ? CLEN_LONG : CLEN_SHORT;
         end
      end
      if (b == 8'h00)
         zeros_seen = (prior == ZRUN_MAX) ? ZRUN_MAX : prior + 2'd1;
      else
         zeros_seen = '0;
      if (fin && in_nal) begin
         endo = p + 1;
         evs.push_back(make_event(EV_TRUNC, nal_kind, code_len, open_start, endo,
                                  endo - open_start, 1'b0));
      end
      stream_pos = p + 1;
      if (fin)
         clear_parser();
      if (evs.size() > 0)
         evs[evs.size()-1].last = 1'b1;
      if (keep)
         foreach (evs[i]) nal_events_due.push_back(evs[i]);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   // bytes that build zero runs and start codes
   function automatic logic [7:0] noise_byte();
      int r;
      r = $urandom_range(9);
      if (r < 5) return 8'h00;
      if (r < 8) return START_BYTE;
      return 8'($urandom_range(255));
   endfunction

   function automatic void add_row(input logic [7:0] b, input bit fin);
      table_row_type r;
      r.b     = b;
      r.fin   = fin;
      r.known = 1'b0;
      r.ev    = no_event;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_known(input logic [7:0] b, input bit fin,
                                     input nal_event_type ev);
      table_row_type r;
      r.b     = b;
      r.fin   = fin;
      r.known = 1'b1;
      r.ev    = ev;
      directed_rows.push_back(r);
   endfunction

   // Offer one byte at the falling edge and hold it until accepted.
   task automatic send_byte(input logic [7:0] b, input bit fin, input bit known,
                            input nal_event_type ev);
      int gap;
      gap = (tx_steady || rx_holding) ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= b;
      req_ch.stream_end <= fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      parse_byte(b, fin, !known);
      if (known)
         nal_events_due.push_back(ev);
      bytes_sent++;
   endtask

   // Sender goes idle until every expected result is back.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (nal_events_due.size() != 0) @(posedge clock);
   endtask

   // One random stream: mostly well-formed NALs, sometimes noise, often cut
   // short so that the final byte lands on a header or a start code.
   task automatic send_stream();
      logic [7:0] s[$];
      int         plen;
      int         cut;
      bit         with_fin;
      if ($urandom_range(5) == 0) begin
         repeat ($urandom_range(30, 4)) s.push_back(noise_byte());
      end else begin
         repeat ($urandom_range(3)) s.push_back(8'($urandom_range(255)));
         repeat ($urandom_range(5, 1)) begin
            repeat (($urandom_range(9) == 0) ? $urandom_range(6, 3) : $urandom_range(3, 2))
               s.push_back(8'h00);
            s.push_back(START_BYTE);
            s.push_back(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255)));
            plen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
            repeat (plen)
               s.push_back(($urandom_range(3) == 0) ? noise_byte() : 8'($urandom_range(255)));
         end
         repeat ($urandom_range(2)) s.push_back(8'h00);
      end
      with_fin = ($urandom_range(4) != 0);
      if (with_fin && $urandom_range(2) == 0) begin
         cut = $urandom_range(s.size() - 1);
         s   = s[0:cut];
      end
      tx_steady = ($urandom_range(3) == 0);
      foreach (s[i])
         send_byte(s[i], with_fin && (i == s.size() - 1), 1'b0, no_event);
   endtask

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   function automatic void check_field(input string what, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0d, got %0d", what, want_v, got_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (nal_events_due.size() == 0) begin
            $error("result item with nothing expected: kind %0d offset %0d",
                   rsp_ch.event_kind, rsp_ch.nal_offset);
            failures++;
         end else begin
            want = nal_events_due.pop_front();
            check_field("event_kind",     32'(want.kind),     32'(rsp_ch.event_kind));
            check_field("hdr_code",       32'(want.hdr_code), 32'(rsp_ch.hdr_code));
            check_field("start_code_len", 32'(want.clen),     32'(rsp_ch.start_code_len));
            check_field("nal_offset",     want.off,           rsp_ch.nal_offset);
            check_field("end_offset",     want.endo,          rsp_ch.end_offset);
            check_field("nal_length",     want.len,           rsp_ch.nal_length);
            check_field("last_of_run",    32'(want.last),     32'(rsp_ch.last_of_run));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random ready pattern, steady stretches, one long hold-off
   // -------------------------------------------------------------------------
   initial begin
      int n;
      int steady;
      bit hold_done;
      steady    = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         if (!hold_done && bytes_sent >= HOLD_AT) begin
            // sender keeps streaming meanwhile; the job queue must fill
            hold_done  = 1'b1;
            rx_holding = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ch.ready <= 1'b0;
            end
            rx_holding = 1'b0;
         end
         if (steady == 0 && $urandom_range(30) == 0)
            steady = $urandom_range(80, 20);
         if (steady > 0) begin
            n = 0;
            steady--;
         end else begin
            n = pick_gap();
         end
         repeat (n) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      bit drained;
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = 8'h00;
      req_ch.stream_end = 1'b0;
      failures          = 0;
      bytes_sent        = 0;
      tx_steady         = 1'b0;
      rx_holding        = 1'b0;
      drained           = 1'b0;
      no_event          = make_event(EV_HEADER, '0, '0, '0, '0, '0, 1'b0);
      clear_parser();

      // Stream A: long start code, header 0xFF, end at 00 00 01, a header
      // byte of 00 giving a zero-length NAL, end at 00 00 00, saturated
      // zero run, then a header on the final byte (header plus truncation).
      add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0);
      add_row(8'h01, 1'b0);
      add_known(8'hFF, 1'b0, make_event(EV_HEADER, 5'd31, CLEN_LONG, 32'd4, 32'd0, 32'd0, 1'b1));
      add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0);
      add_known(8'h01, 1'b0, make_event(EV_END, 5'd31, CLEN_LONG, 32'd4, 32'd5, 32'd1, 1'b1));
      add_known(8'h00, 1'b0, make_event(EV_HEADER, 5'd0, CLEN_SHORT, 32'd8, 32'd0, 32'd0, 1'b1));
      add_row(8'h00, 1'b0);
      add_known(8'h01, 1'b0, make_event(EV_END, 5'd0, CLEN_SHORT, 32'd8, 32'd8, 32'd0, 1'b1));
      add_known(8'h65, 1'b0, make_event(EV_HEADER, 5'd5, CLEN_SHORT, 32'd11, 32'd0, 32'd0, 1'b1));
      add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0);
      add_known(8'h00, 1'b0, make_event(EV_END, 5'd5, CLEN_SHORT, 32'd11, 32'd12, 32'd1, 1'b1));
      add_row(8'h00, 1'b0);
      add_row(8'h01, 1'b0);
      add_row(8'h67, 1'b1);
      // Stream B: junk before the start code, start code on the final byte.
      add_row(8'hAA, 1'b0);
      add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0);
      add_row(8'h01, 1'b1);
      // Stream C: offsets restart at 0, NAL truncated by the stream end.
      add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0);
      add_row(8'h01, 1'b0);
      add_known(8'h41, 1'b0, make_event(EV_HEADER, 5'd1, CLEN_SHORT, 32'd3, 32'd0, 32'd0, 1'b1));
      add_known(8'h7E, 1'b1, make_event(EV_TRUNC, 5'd1, CLEN_SHORT, 32'd3, 32'd5, 32'd2, 1'b1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].known,
                   directed_rows[i].ev);
      drain_results();

      while (bytes_sent < directed_rows.size() + RANDOM_BYTES) begin
         if (!drained && bytes_sent >= DRAIN_AT) begin
            drained = 1'b1;
            drain_results();
         end
         send_stream();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("annexb_nal_boundary_finder_unit test passed");
      else
         $display("annexb_nal_boundary_finder_unit test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10000000;
      $display("annexb_nal_boundary_finder_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire
